### rtl/core/gtrs_pkg.sv
// Shared types and constants of the gap tolerant row span finder.
package gtrs_pkg;

   localparam int DEFAULT_LINE_WIDTH = 1024;
   localparam int QUEUE_DEPTH        = 4;

   localparam int X_W     = 10;
   localparam int ROW_W   = 10;
   localparam int GAP_W   = 10;
   localparam int PIX_W   = 11;
   localparam int CSR_W   = 11;

   localparam logic [GAP_W-1:0] MAX_GAP_RESET  = 10'd0;
   localparam logic [PIX_W-1:0] MIN_PIXELS_RESET = 11'd3;

   typedef enum logic [0:0] {
      CSR_MAX_GAP    = 1'b0,
      CSR_MIN_PIXELS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [X_W-1:0]   pixel_x;
      logic [ROW_W-1:0] pixel_row;
      logic             row_end;
   } req_type;

   typedef struct packed {
      logic [X_W-1:0]   span_start_x;
      logic [X_W-1:0]   span_end_x;
      logic [ROW_W-1:0] span_row;
      logic [PIX_W-1:0] span_pixels;
      logic             last_result;
   } rsp_type;

   // Up to two spans closed by one pixel, in emission order
   typedef struct packed {
      logic    first_valid;
      logic    second_valid;
      rsp_type first;
      rsp_type second;
   } push_type;

endpackage

### rtl/core/gtrs_tracker.sv
// Open span state, gap test and span closing for each accepted pixel.
module gtrs_tracker
   import gtrs_pkg::*;
#(
   parameter int LINE_WIDTH = DEFAULT_LINE_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  req_type             pixel,
   input  logic [GAP_W-1:0]    max_gap,
   input  logic [PIX_W-1:0]    min_pixels,
   output push_type            push
);

   localparam int CNT_W = $clog2(LINE_WIDTH + 1);
   localparam int CMP_W = (CNT_W > PIX_W) ? CNT_W : PIX_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_WIDTH);

   logic [X_W-1:0]   start_x_ff, start_x_in;
   logic [X_W-1:0]   prev_x_ff, prev_x_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             open_ff, open_in;

   logic             far;
   logic             close_a;
   logic             emit_a;
   logic             emit_b;
   logic [CNT_W-1:0] count_next;
   logic [X_W-1:0]   start_next;
   logic [ROW_W-1:0] row_next;
   rsp_type          span_a;
   rsp_type          span_b;

   always_comb begin
      // gap above max_gap means x > previous + max_gap + 1
      far = {2'b00, pixel.pixel_x} >
            ({2'b00, prev_x_ff} + {2'b00, max_gap} + 12'd1);
      close_a = open_ff && ((pixel.pixel_row != row_ff) || far);
      emit_a  = close_a && (CMP_W'(count_ff) >= CMP_W'(min_pixels));

      if (close_a || !open_ff) begin
         start_next = pixel.pixel_x;
         row_next   = pixel.pixel_row;
         count_next = CNT_W'(1);
      end else begin
         start_next = start_x_ff;
         row_next   = row_ff;
         count_next = (count_ff < CNT_MAX) ? count_ff + CNT_W'(1) : count_ff;
      end
      emit_b = pixel.row_end && (CMP_W'(count_next) >= CMP_W'(min_pixels));

      span_a.span_start_x = start_x_ff;
      span_a.span_end_x   = prev_x_ff;
      span_a.span_row     = row_ff;
      span_a.span_pixels  = PIX_W'(count_ff);
      span_a.last_result  = !emit_b;

      span_b.span_start_x = start_next;
      span_b.span_end_x   = pixel.pixel_x;
      span_b.span_row     = row_next;
      span_b.span_pixels  = PIX_W'(count_next);
      span_b.last_result  = 1'b1;

      push.first_valid  = accept && (emit_a || emit_b);
      push.second_valid = accept && emit_a && emit_b;
      push.first        = emit_a ? span_a : span_b;
      push.second       = span_b;

      start_x_in = start_x_ff;
      prev_x_in  = prev_x_ff;
      row_in     = row_ff;
      count_in   = count_ff;
      open_in    = open_ff;
      if (accept) begin
         start_x_in = start_next;
         row_in     = row_next;
         prev_x_in  = pixel.pixel_x;
         // row end closes the span it just joined
         open_in    = !pixel.row_end;
         count_in   = pixel.row_end ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         prev_x_ff  <= '0;
         row_ff     <= '0;
         count_ff   <= '0;
         open_ff    <= 1'b0;
      end else begin
         start_x_ff <= start_x_in;
         prev_x_ff  <= prev_x_in;
         row_ff     <= row_in;
         count_ff   <= count_in;
         open_ff    <= open_in;
      end
   end

endmodule

### rtl/core/gtrs_result_queue.sv
// Result queue: up to two spans in and one out a cycle, unless stalled.
module gtrs_result_queue
   import gtrs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_payload
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic [CNT_W-1:0] push_n;
   logic [PTR_W-1:0] tail_next;

   always_comb begin
      pop       = rsp_valid && !rsp_stall;
      push_n    = CNT_W'(push.first_valid) + CNT_W'(push.second_valid);
      tail_next = tail_ff + PTR_W'(1);
      head_in   = pop ? head_ff + PTR_W'(1) : head_ff;
      tail_in   = tail_ff + PTR_W'(push_n);
      count_in  = count_ff + push_n - CNT_W'(pop);
   end

   // Keep space for a full pair whatever the receiver does
   assign room        = count_ff <= CNT_W'(QUEUE_DEPTH - 2);
   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = entry_ff[head_ff];

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[tail_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_ff[tail_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/core/gap_tolerant_row_span_finder_core.sv
// Top level of the gap tolerant row span finder.
// Pixels of one colour arrive on the req_ channel, ascending in x within a
// row, each with its row and a last-in-row flag. Closed spans that hold at
// least the configured minimum pixel count leave on the rsp_ channel;
// last_result marks the final span caused by one pixel (a pixel closes at
// most two spans).
// The csr_ port writes max_gap (index 0) and the minimum span size (index 1).
// A span closed by an accepted pixel is written into the result queue and
// offered on rsp_ from there. Throughput: one pixel a cycle while
// req_stall is low, set by the open span register update; the output side
// moves one span a cycle unless rsp_stall is high.
// A four-entry result queue parts the channels: req_stall rises when it
// holds more than two spans, so a stalled receiver backs up the input.
// Reset clears the open span, empties the queue and restores the register
// defaults (max_gap 0, minimum span size 3).
module gap_tolerant_row_span_finder_core
   import gtrs_pkg::*;
#(
   parameter int LINE_WIDTH = DEFAULT_LINE_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_payload,
   input  logic             csr_write_enable,
   input  csr_index_type    csr_index,
   input  logic [CSR_W-1:0] csr_write_data
);

   logic [GAP_W-1:0] max_gap_ff, max_gap_in;
   logic [PIX_W-1:0] min_pixels_ff, min_pixels_in;
   logic             room;
   logic             accept;
   push_type         push;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   always_comb begin
      max_gap_in    = max_gap_ff;
      min_pixels_in = min_pixels_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_GAP:    max_gap_in    = csr_write_data[GAP_W-1:0];
            CSR_MIN_PIXELS: min_pixels_in = csr_write_data[PIX_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff    <= MAX_GAP_RESET;
         min_pixels_ff <= MIN_PIXELS_RESET;
      end else begin
         max_gap_ff    <= max_gap_in;
         min_pixels_ff <= min_pixels_in;
      end
   end

   gtrs_tracker #(
      .LINE_WIDTH (LINE_WIDTH)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .pixel      (req_payload),
      .max_gap    (max_gap_ff),
      .min_pixels (min_pixels_ff),
      .push       (push)
   );

   gtrs_result_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
